// ===== hw/rtl/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit.
// Used by the top level only; needs clock and reset in scope.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMPL(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define RAU_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
   localparam int DataWidth = 32;
   localparam int OpWidth   = 3;
   localparam int StWidth   = 2;

   localparam logic [OpWidth-1:0] OP_REDUCE = 3'd0;
   localparam logic [OpWidth-1:0] OP_ADD    = 3'd1;
   localparam logic [OpWidth-1:0] OP_SUB    = 3'd2;
   localparam logic [OpWidth-1:0] OP_MUL    = 3'd3;
   localparam logic [OpWidth-1:0] OP_DIV    = 3'd4;

   localparam logic [StWidth-1:0] ST_OK   = 2'd0;
   localparam logic [StWidth-1:0] ST_WRAP = 2'd1;
   localparam logic [StWidth-1:0] ST_ZERO = 2'd2;

   // datapath commands issued by the controller
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,     // capture operands
      CMD_MUL_ND,   // p = an*bd (or an*bn for multiply)
      CMD_MUL_DD,   // den = ad*bd (or ad*bn for divide)
      CMD_MUL_NB,   // p = bn * ad
      CMD_SUM,      // num = n1 +/- n2
      CMD_MAGS,     // take magnitudes, start gcd
      CMD_GCD,      // one binary gcd step (halve or subtract)
      CMD_DIVINIT,  // set up divider for a part
      CMD_DIVSTEP,  // one restoring division step
      CMD_FINISH    // apply signs, latch result
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       sel_den;  // division of den part when set
   } ctl_type;

   typedef struct packed {
      logic gcd_done;
      logic div_done;
      logic den_diff;
   } sts_type;
endpackage

// ===== hw/rtl/rau_if.sv =====
// Valid/ready channel interface for the rational arithmetic unit.
// Payload type is a parameter.
interface rau_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/rau_datapath.sv =====
// Datapath: operand registers, shared multiplier, gcd and divider.
// Depends on rau_pkg.
module rau_datapath #(
   parameter int DATA_WIDTH = rau_pkg::DataWidth
) (
   input  logic                        clock,
   input  logic [rau_pkg::OpWidth-1:0] op,
   input  logic [DATA_WIDTH-1:0]       a_num,
   input  logic [DATA_WIDTH-1:0]       a_den,
   input  logic [DATA_WIDTH-1:0]       b_num,
   input  logic [DATA_WIDTH-1:0]       b_den,
   input  rau_pkg::ctl_type            ctl,
   output rau_pkg::sts_type            sts,
   output logic [DATA_WIDTH-1:0]       res_num,
   output logic [DATA_WIDTH-1:0]       res_den,
   output logic [rau_pkg::StWidth-1:0] res_status
);
   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [rau_pkg::OpWidth-1:0] op_ff;
   logic [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [W-1:0] n1_ff, n2_ff, num_ff, den_ff;
   logic         wrap_ff;
   logic [W-1:0] gp_ff, gq_ff, mn_ff, md_ff;
   logic [CW-1:0] shift_ff;
   logic [W-1:0] quo_ff, rem_ff, dvd_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0] qn_ff;

   // multiplier operand select
   logic [W-1:0] mx, my;
   always_comb begin
      mx = an_ff;
      my = bd_ff;
      case (ctl.cmd)
         rau_pkg::CMD_MUL_ND: begin
            mx = an_ff;
            my = (op_ff == rau_pkg::OP_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::CMD_MUL_DD: begin
            mx = ad_ff;
            my = (op_ff == rau_pkg::OP_DIV) ? bn_ff : bd_ff;
         end
         rau_pkg::CMD_MUL_NB: begin
            mx = bn_ff;
            my = ad_ff;
         end
         default: ;
      endcase
   end

   logic [W-1:0] mag_x, mag_y, prod_mag_lo;
   logic [2*W-1:0] prod_mag;
   logic [W-1:0] prod;
   logic         prod_neg, prod_wrap;
   assign mag_x    = mx[W-1] ? (~mx + 1'b1) : mx;
   assign mag_y    = my[W-1] ? (~my + 1'b1) : my;
   assign prod_neg = mx[W-1] ^ my[W-1];
   assign prod_mag = {{W{1'b0}}, mag_x} * {{W{1'b0}}, mag_y};
   assign prod_mag_lo = prod_mag[W-1:0];
   assign prod     = prod_neg ? (~prod_mag_lo + 1'b1) : prod_mag_lo;
   // wrap when magnitude exceeds 2^(W-1) (neg) or 2^(W-1)-1 (pos)
   always_comb begin
      if (prod_mag[2*W-1:W] != '0) prod_wrap = 1'b1;
      else if (prod_neg) prod_wrap = prod_mag[W-1] && (prod_mag[W-2:0] != '0);
      else prod_wrap = prod_mag[W-1];
   end

   logic [W-1:0] n1_sel, n2_sel, sum;
   logic         sum_wrap, is_sub;
   assign is_sub = (op_ff == rau_pkg::OP_SUB);
   assign n1_sel = sts.den_diff ? n1_ff : an_ff;
   assign n2_sel = sts.den_diff ? n2_ff : bn_ff;
   assign sum    = is_sub ? (n1_sel - n2_sel) : (n1_sel + n2_sel);
   assign sum_wrap = ((n1_sel[W-1] ^ n2_sel[W-1]) == is_sub) &&
                     (sum[W-1] != n1_sel[W-1]);

   assign sts.den_diff = (ad_ff != bd_ff);
   assign sts.gcd_done = (gq_ff == '0);
   assign sts.div_done = (cnt_ff == '0);

   // binary gcd helpers
   logic [W-1:0] diff;
   logic         p_ev, q_ev;
   assign p_ev = ~gp_ff[0];
   assign q_ev = ~gq_ff[0];
   assign diff = (gp_ff > gq_ff) ? (gp_ff - gq_ff) : (gq_ff - gp_ff);

   logic [W-1:0] gcd_val, dsor;
   assign gcd_val = gp_ff << shift_ff;
   assign dsor = gcd_val;

   logic [W:0] trial;
   logic [W-1:0] rem_sh;
   assign rem_sh = {rem_ff[W-2:0], dvd_ff[W-1]};
   assign trial  = {rem_ff[W-1], rem_sh} - {1'b0, dsor};

   logic [W-1:0] mn_c, md_c;
   assign mn_c = num_ff[W-1] ? (~num_ff + 1'b1) : num_ff;
   assign md_c = den_ff[W-1] ? (~den_ff + 1'b1) : den_ff;

   always_ff @(posedge clock) begin
      case (ctl.cmd)
         rau_pkg::CMD_LOAD: begin
            op_ff   <= op;
            an_ff   <= a_num;
            ad_ff   <= a_den;
            bn_ff   <= b_num;
            bd_ff   <= b_den;
            wrap_ff <= 1'b0;
            num_ff  <= a_num;
            den_ff  <= a_den;
         end
         rau_pkg::CMD_MUL_ND: begin
            n1_ff   <= prod;
            num_ff  <= prod;
            wrap_ff <= wrap_ff | prod_wrap;
         end
         rau_pkg::CMD_MUL_DD: begin
            den_ff  <= prod;
            wrap_ff <= wrap_ff | prod_wrap;
         end
         rau_pkg::CMD_MUL_NB: begin
            n2_ff   <= prod;
            wrap_ff <= wrap_ff | prod_wrap;
         end
         rau_pkg::CMD_SUM: begin
            num_ff  <= sum;
            if (!sts.den_diff) den_ff <= ad_ff;
            wrap_ff <= wrap_ff | sum_wrap;
         end
         rau_pkg::CMD_MAGS: begin
            mn_ff    <= mn_c;
            md_ff    <= md_c;
            shift_ff <= '0;
            // gcd(x,0)=x: keep q as the zero-test operand
            if (mn_c == '0) begin
               gp_ff <= md_c;
               gq_ff <= '0;
            end else if (md_c == '0) begin
               gp_ff <= mn_c;
               gq_ff <= '0;
            end else begin
               gp_ff <= mn_c;
               gq_ff <= md_c;
            end
         end
         rau_pkg::CMD_GCD: begin
            if (p_ev && q_ev) begin
               gp_ff    <= gp_ff >> 1;
               gq_ff    <= gq_ff >> 1;
               shift_ff <= shift_ff + 1'b1;
            end else if (p_ev) begin
               gp_ff <= gp_ff >> 1;
            end else if (q_ev) begin
               gq_ff <= gq_ff >> 1;
            end else begin
               gp_ff <= (gp_ff < gq_ff) ? gp_ff : gq_ff;
               gq_ff <= diff;
            end
         end
         rau_pkg::CMD_DIVINIT: begin
            dvd_ff <= ctl.sel_den ? md_ff : mn_ff;
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= CW'(W);
         end
         rau_pkg::CMD_DIVSTEP: begin
            dvd_ff <= {dvd_ff[W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (!trial[W]) begin
               rem_ff <= trial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            if (cnt_ff == CW'(1) && !ctl.sel_den)
               qn_ff <= trial[W] ? {quo_ff[W-2:0], 1'b0} : {quo_ff[W-2:0], 1'b1};
         end
         rau_pkg::CMD_FINISH: begin
            if (gcd_val == '0) begin
               res_num    <= '0;
               res_den    <= '0;
               res_status <= rau_pkg::ST_ZERO;
            end else begin
               res_num    <= num_ff[W-1] ? (~qn_ff + 1'b1) : qn_ff;
               res_den    <= den_ff[W-1] ? (~quo_ff + 1'b1) : quo_ff;
               res_status <= wrap_ff ? rau_pkg::ST_WRAP : rau_pkg::ST_OK;
            end
         end
         default: ;
      endcase
   end
endmodule

// ===== hw/rtl/rau_ctrl.sv =====
// Controller: sequences operand load, products, gcd and the two divisions.
// Depends on rau_pkg.
module rau_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [rau_pkg::OpWidth-1:0] op,
   input  rau_pkg::sts_type            sts,
   output rau_pkg::ctl_type            ctl
);
   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_MAGS, S_GCD,
      S_DINIT_N, S_DIV_N, S_DINIT_D, S_DIV_D, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [rau_pkg::OpWidth-1:0] op_ff;
   logic rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl.cmd     = rau_pkg::CMD_NONE;
      ctl.sel_den = 1'b0;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            ctl.cmd = rau_pkg::CMD_LOAD;
            if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB ||
                op == rau_pkg::OP_MUL || op == rau_pkg::OP_DIV)
               state_in = S_MUL1;
            else
               state_in = S_MAGS;
         end
         S_MUL1: begin
            if ((op_ff == rau_pkg::OP_ADD || op_ff == rau_pkg::OP_SUB) && !sts.den_diff)
               state_in = S_SUM;
            else if (op_ff == rau_pkg::OP_DIV) begin
               // divide: num = an*bd via same select as add path
               ctl.cmd  = rau_pkg::CMD_MUL_ND;
               state_in = S_MUL2;
            end else begin
               ctl.cmd  = rau_pkg::CMD_MUL_ND;
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            ctl.cmd  = rau_pkg::CMD_MUL_DD;
            state_in = (op_ff == rau_pkg::OP_ADD || op_ff == rau_pkg::OP_SUB)
                       ? S_MUL3 : S_MAGS;
         end
         S_MUL3: begin
            ctl.cmd  = rau_pkg::CMD_MUL_NB;
            state_in = S_SUM;
         end
         S_SUM: begin
            ctl.cmd  = rau_pkg::CMD_SUM;
            state_in = S_MAGS;
         end
         S_MAGS: begin
            ctl.cmd  = rau_pkg::CMD_MAGS;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (sts.gcd_done) state_in = S_DINIT_N;
            else ctl.cmd = rau_pkg::CMD_GCD;
         end
         S_DINIT_N: begin
            ctl.cmd  = rau_pkg::CMD_DIVINIT;
            state_in = S_DIV_N;
         end
         S_DIV_N: begin
            if (sts.div_done) state_in = S_DINIT_D;
            else ctl.cmd = rau_pkg::CMD_DIVSTEP;
         end
         S_DINIT_D: begin
            ctl.cmd     = rau_pkg::CMD_DIVINIT;
            ctl.sel_den = 1'b1;
            state_in    = S_DIV_D;
         end
         S_DIV_D: begin
            ctl.sel_den = 1'b1;
            if (sts.div_done) state_in = S_FIN;
            else ctl.cmd = rau_pkg::CMD_DIVSTEP;
         end
         S_FIN: begin
            ctl.cmd  = rau_pkg::CMD_FINISH;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= rau_pkg::OP_REDUCE;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && req_valid) op_ff <= op;
         if (state_ff == S_FIN) rsp_valid_ff <= 1'b1;
         else if (state_ff == S_OUT && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end
endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one item (opcode, a_num/a_den, b_num/b_den) gives one
// reduced fraction with status. After an item is taken the unit forms two products for
// multiply/divide, none for add/subtract with a shared denominator, three with
// different denominators and none for reduce, then runs the binary-gcd loop (input
// dependent) and the two bit-serial divisions, which set the run time. One item is in
// work at a time; the next item can be taken in the cycle after the result is taken.
// Depends on rau_pkg, rau_if, rau_ctrl, rau_datapath.
module rational_arithmetic_unit #(
   parameter int DATA_WIDTH = rau_pkg::DataWidth
) (
   input logic clock,
   input logic reset,
   rau_if.sink   req,
   rau_if.source rsp
);
   `include "rational_arithmetic_unit_assert.svh"

   rau_pkg::ctl_type ctl;
   rau_pkg::sts_type sts;
   logic             zero_held;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .op        (req.payload.opcode),
      .sts       (sts),
      .ctl       (ctl)
   );

   rau_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock      (clock),
      .op         (req.payload.opcode),
      .a_num      (req.payload.a_num),
      .a_den      (req.payload.a_den),
      .b_num      (req.payload.b_num),
      .b_den      (req.payload.b_den),
      .ctl        (ctl),
      .sts        (sts),
      .res_num    (rsp.payload.res_num),
      .res_den    (rsp.payload.res_den),
      .res_status (rsp.payload.status)
   );

   assign zero_held = rsp.valid && (rsp.payload.status == rau_pkg::ST_ZERO) && !rsp.ready;

   `RAU_ASSERT_IMPL(a_no_accept_busy, rsp.valid, !req.ready)
   `RAU_ASSERT_NEXT(a_zero_status, zero_held, rsp.payload.res_num == '0)
   `RAU_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, !req.ready)
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for rational_arithmetic_unit: directed table, then random items.
// Checks each result against a typed expected value or a behavioral fraction predictor.
// Depends on rau_pkg, rau_if and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = rau_pkg::DataWidth;
   localparam int OW = rau_pkg::OpWidth;
   localparam int SW = rau_pkg::StWidth;
   localparam int NumRandom = 430;
   localparam int WatchLimit = 4000;
   localparam int HoldOff = 500;

   typedef struct packed {
      logic [OW-1:0] opcode;
      logic [W-1:0]  a_num;
      logic [W-1:0]  a_den;
      logic [W-1:0]  b_num;
      logic [W-1:0]  b_den;
   } req_type;

   typedef struct packed {
      logic [W-1:0]  res_num;
      logic [W-1:0]  res_den;
      logic [SW-1:0] status;
   } rsp_type;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type result;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   rau_if #(.payload_type(req_type)) req ();
   rau_if #(.payload_type(rsp_type)) rsp ();

   rational_arithmetic_unit u_top (.clock(clock), .reset(reset), .req(req.sink),
      .rsp(rsp.source));

   always #4 clock = ~clock;

   rsp_type pending_fractions[$];
   int   error_count = 0;
   int   sent_count = 0;
   int   recv_count = 0;
   int   op_count[8];
   int   wrap_count = 0;
   int   zero_count = 0;
   int   idle_cycles = 0;
   bit   stim_done = 0;

   task automatic report(string what, logic [W-1:0] got, logic [W-1:0] exp);
      error_count++;
      $display("MISMATCH item %0d %s: got %h expected %h", recv_count, what, got, exp);
   endtask

   function automatic logic [W-1:0] mul_wrap(logic [W-1:0] x, logic [W-1:0] y,
                                              ref bit wrap);
      logic signed [2*W-1:0] p;
      p = $signed({{W{x[W-1]}}, x}) * $signed({{W{y[W-1]}}, y});
      if (p != {{W{p[W-1]}}, p[W-1:0]}) wrap = 1;
      return p[W-1:0];
   endfunction

   function automatic logic [W-1:0] magn(logic [W-1:0] v);
      return v[W-1] ? -v : v;
   endfunction

   function automatic rsp_type reduced_fraction(req_type r);
      logic [W-1:0] n1, n2, num, den, mn, md, g, q, t;
      logic [W:0]   s;
      bit wrap;
      rsp_type o;
      wrap = 0;
      case (r.opcode)
         rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            n1 = r.a_num;
            n2 = r.b_num;
            den = r.a_den;
            if (r.a_den != r.b_den) begin
               n1 = mul_wrap(r.a_num, r.b_den, wrap);
               den = mul_wrap(r.a_den, r.b_den, wrap);
               n2 = mul_wrap(r.b_num, r.a_den, wrap);
            end
            if (r.opcode == rau_pkg::OP_ADD) s = {n1[W-1], n1} + {n2[W-1], n2};
            else s = {n1[W-1], n1} - {n2[W-1], n2};
            if (s[W] != s[W-1]) wrap = 1;
            num = s[W-1:0];
         end
         rau_pkg::OP_MUL: begin
            num = mul_wrap(r.a_num, r.b_num, wrap);
            den = mul_wrap(r.a_den, r.b_den, wrap);
         end
         rau_pkg::OP_DIV: begin
            num = mul_wrap(r.a_num, r.b_den, wrap);
            den = mul_wrap(r.a_den, r.b_num, wrap);
         end
         default: begin
            num = r.a_num;
            den = r.a_den;
         end
      endcase
      mn = magn(num);
      md = magn(den);
      g = mn;
      q = md;
      while (q != 0) begin
         t = g % q;
         g = q;
         q = t;
      end
      if (g == 0) begin
         o = '{res_num: '0, res_den: '0, status: rau_pkg::ST_ZERO};
      end else begin
         o.res_num = num[W-1] ? -(mn / g) : mn / g;
         o.res_den = den[W-1] ? -(md / g) : md / g;
         o.status = wrap ? rau_pkg::ST_WRAP : rau_pkg::ST_OK;
      end
      return o;
   endfunction

   function automatic logic [W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(W-1){1'b0}}};
         1: return {1'b0, {(W-1){1'b1}}};
         2: return '0;
         3: return W'($signed($urandom_range(0, 2)) - 1);
         4, 5: return W'(int'($urandom_range(0, 40)) - 20);
         6: return W'(int'($urandom_range(0, 4000)) - 2000) * W'($urandom_range(1, 12));
         7: return W'(1) << $urandom_range(0, W - 1);
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.opcode = ($urandom_range(0, 15) == 0) ? OW'($urandom_range(5, 7))
                                               : OW'($urandom_range(0, 4));
      r.a_num = pick_operand();
      r.a_den = pick_operand();
      r.b_num = pick_operand();
      r.b_den = ($urandom_range(0, 2) == 0) ? r.a_den : pick_operand();
      if ($urandom_range(0, 30) == 0) begin
         r.a_num = '0;
         r.a_den = '0;
      end
      return r;
   endfunction

   localparam logic [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};

   function automatic row_type mk(logic [OW-1:0] op, int an, int ad, int bn, int bd,
                                  bit typed = 0, int rn = 0, int rd = 0,
                                  logic [SW-1:0] st = rau_pkg::ST_OK);
      row_type x;
      x.item = '{opcode: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
      x.typed = typed;
      x.result = '{res_num: rn, res_den: rd, status: st};
      return x;
   endfunction

   task automatic send(req_type r, rsp_type exp);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= r;
      do @(posedge clock); while (!req.ready);
      pending_fractions.push_back(exp);
      op_count[r.opcode]++;
      if (exp.status == rau_pkg::ST_WRAP) wrap_count++;
      if (exp.status == rau_pkg::ST_ZERO) zero_count++;
      sent_count++;
   endtask

   initial begin
      row_type rows[$];
      req_type r;
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      rows.push_back(mk(rau_pkg::OP_REDUCE, 6, 4, 0, 0, 1, 3, 2));
      rows.push_back(mk(rau_pkg::OP_REDUCE, 0, 0, -1, -1, 1, 0, 0, rau_pkg::ST_ZERO));
      rows.push_back(mk(rau_pkg::OP_REDUCE, -6, 4, 5, 5, 1, -3, 2));
      rows.push_back(mk(rau_pkg::OP_REDUCE, MinVal, 2, 0, 0, 1, -(1 << 30), 1));
      rows.push_back(mk(rau_pkg::OP_REDUCE, MinVal, MinVal, 0, 0, 1, -1, -1));
      rows.push_back(mk(rau_pkg::OP_REDUCE, MinVal, 1, 0, 0, 1, MinVal, 1));
      rows.push_back(mk(rau_pkg::OP_REDUCE, MaxVal, MaxVal, 0, 0, 1, 1, 1));
      rows.push_back(mk(rau_pkg::OP_REDUCE, 7, 0, 0, 0, 1, 1, 0));
      rows.push_back(mk(rau_pkg::OP_ADD, 1, 3, 1, 3, 1, 2, 3));
      rows.push_back(mk(rau_pkg::OP_ADD, 0, 0, 0, 0, 1, 0, 0, rau_pkg::ST_ZERO));
      rows.push_back(mk(rau_pkg::OP_ADD, MaxVal, 1, 1, 1, 1, MinVal, 1, rau_pkg::ST_WRAP));
      rows.push_back(mk(rau_pkg::OP_SUB, 1, 2, 1, 3, 1, 1, 6));
      rows.push_back(mk(rau_pkg::OP_SUB, MinVal, 1, 1, 1, 1, MaxVal, 1, rau_pkg::ST_WRAP));
      rows.push_back(mk(rau_pkg::OP_MUL, 2, 3, 3, 4, 1, 1, 2));
      rows.push_back(mk(rau_pkg::OP_MUL, MaxVal, 1, MaxVal, 1, 1, 1, 1, rau_pkg::ST_WRAP));
      rows.push_back(mk(rau_pkg::OP_DIV, 1, 2, 3, 4, 1, 2, 3));
      rows.push_back(mk(rau_pkg::OP_DIV, 1, 2, 0, 5, 1, 1, 0));
      rows.push_back(mk(rau_pkg::OP_DIV, 0, 1, 0, 1, 1, 0, 0, rau_pkg::ST_ZERO));
      // spare opcodes behave as reduce
      rows.push_back(mk(3'd5, 4, 8, 9, 9, 1, 1, 2));
      rows.push_back(mk(3'd6, -4, -8, 1, 1, 1, -1, -2));
      rows.push_back(mk(3'd7, 9, -3, 1, 1, 1, 3, -1));
      rows.push_back(mk(rau_pkg::OP_ADD, 7, -21, -5, 14, 0));
      rows.push_back(mk(rau_pkg::OP_SUB, MinVal, MinVal, MaxVal, 3, 0));
      rows.push_back(mk(rau_pkg::OP_MUL, MinVal, -1, -1, MinVal, 0));
      rows.push_back(mk(rau_pkg::OP_DIV, -123456, 789, 4096, -65536, 0));
      foreach (rows[i])
         send(rows[i].item, rows[i].typed ? rows[i].result : reduced_fraction(rows[i].item));
      repeat (NumRandom) begin
         r = random_item();
         send(r, reduced_fraction(r));
      end
      req.valid <= 1'b0;
      stim_done = 1;
   end

   // receiver: random stalls, one long hold-off once things are running
   initial begin
      int gap;
      bit held;
      held = 0;
      @(negedge reset);
      @(posedge clock);
      rsp.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp.valid && rsp.ready));
         gap = (!held && recv_count >= 60) ? HoldOff : $urandom_range(0, 3);
         if (gap >= HoldOff) held = 1;
         if ($urandom_range(0, 3) == 0) gap = held && gap == HoldOff ? gap : 0;
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp.valid && rsp.ready) begin
         recv_count++;
         if (pending_fractions.size() == 0) begin
            report("unexpected item res_num", rsp.payload.res_num, 'x);
         end else begin
            exp = pending_fractions.pop_front();
            if (rsp.payload.res_num !== exp.res_num)
               report("res_num", rsp.payload.res_num, exp.res_num);
            if (rsp.payload.res_den !== exp.res_den)
               report("res_den", rsp.payload.res_den, exp.res_den);
            if (rsp.payload.status !== exp.status)
               report("status", W'(rsp.payload.status), W'(exp.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("timeout after %0d idle cycles, %0d results missing", idle_cycles,
            pending_fractions.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      wait (stim_done && pending_fractions.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d items: reduce %0d add %0d sub %0d mul %0d div %0d spare %0d",
         sent_count, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
         op_count[5] + op_count[6] + op_count[7]);
      $display("wrapped results %0d, zero-gcd results %0d, mismatches %0d", wrap_count,
         zero_count, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
